FILE: rtl/timed_stereo_audio_transmit_fifo_assert.svh
// Assertion macros used by the checker file of the audio transmit FIFO
`ifndef TIMED_STEREO_AUDIO_TRANSMIT_FIFO_ASSERT_SVH
`define TIMED_STEREO_AUDIO_TRANSMIT_FIFO_ASSERT_SVH

// same-cycle implication, clk and arst_n taken from the enclosing scope
`define TSATF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSATF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tsatf_pkg.sv
// Shared constants for the timed stereo audio transmit FIFO
`timescale 1ns / 1ps
package tsatf_pkg;
	localparam int WORD_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'd1;

	// item modes
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_PUSH = 1'b1;
endpackage

FILE: rtl/timed_stereo_audio_transmit_fifo.sv
// Top level: word FIFO with period-timed stereo sample pop
`timescale 1ns / 1ps
// Takes one beat per clock while in_stall is low and gives one result beat per
// input beat, via the input register and then the result register. The word
// store has one write port and two registered read ports (read pointer and the
// entry after it), so one beat does a push or a full stereo pop. Both sides may
// idle or stall freely; the input stalls only when both registers are full and
// the result one is held. The user must write period and enable through the
// plain write port while no beat is in flight; the block does not enforce it.
module timed_stereo_audio_transmit_fifo #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [tsatf_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [tsatf_pkg::CFG_DATA_W-1:0]      wr_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  mode,
	input  logic [tsatf_pkg::WORD_W-1:0]          push_word,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  sample_valid,
	output logic signed [tsatf_pkg::WORD_W-1:0]   left_sample,
	output logic signed [tsatf_pkg::WORD_W-1:0]   right_sample,
	output logic                                  underrun,
	output logic                                  irq,
	output logic                                  fifo_empty,
	output logic                                  fifo_full,
	output logic                                  overflow
);
	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

	logic [tsatf_pkg::WORD_W-1:0] period_q;
	logic                         enable_q;

	logic [tsatf_pkg::WORD_W-1:0] timer_q;
	logic [AW-1:0]                rd_ptr_q, wr_ptr_q;
	logic [CW-1:0]                count_q;

	logic [tsatf_pkg::WORD_W-1:0] mem [FIFO_DEPTH];

	// input register
	logic                         valid_s1;
	logic                         mode_s1;
	logic [tsatf_pkg::WORD_W-1:0] word_s1;

	// result register
	logic                         valid_s2;
	logic                         sample_s2, left_take_s2, right_take_s2;
	logic                         under_s2, irq_s2, empty_s2, full_s2, ovf_s2;
	logic [tsatf_pkg::WORD_W-1:0] rd0_s2, rd1_s2;

	logic                         s2_ready, adv_s1, in_take;
	logic                         is_push, is_tick, push_ok, fire;
	logic [tsatf_pkg::WORD_W-1:0] timer_inc;
	logic [AW-1:0]                rd_nxt, rd_nxt2, wr_nxt, rd_ptr_d;
	logic [CW-1:0]                pops, count_d;
	logic                         cnt_ge1, cnt_ge2, full_now;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == LAST_IDX) ? '0 : p + AW'(1);
	endfunction

	assign s2_ready = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !s2_ready;
	assign in_take  = in_valid && !in_stall;
	assign adv_s1   = valid_s1 && s2_ready;

	assign is_push  = adv_s1 && (mode_s1 == tsatf_pkg::MODE_PUSH);
	assign is_tick  = adv_s1 && (mode_s1 == tsatf_pkg::MODE_TICK) && enable_q;
	assign full_now = (count_q == FULL_CNT);
	assign push_ok  = is_push && !full_now;

	assign timer_inc = timer_q + tsatf_pkg::WORD_W'(1);
	assign fire      = is_tick && (timer_inc >= period_q);

	assign cnt_ge1 = (count_q != '0);
	assign cnt_ge2 = (count_q >= CW'(2));
	assign pops    = !fire ? '0 : (cnt_ge2 ? CW'(2) : (cnt_ge1 ? CW'(1) : '0));

	assign rd_nxt  = wrap_inc(rd_ptr_q);
	assign rd_nxt2 = wrap_inc(rd_nxt);
	assign wr_nxt  = wrap_inc(wr_ptr_q);

	always_comb begin
		rd_ptr_d = rd_ptr_q;
		if (fire && cnt_ge2) begin
			rd_ptr_d = rd_nxt2;
		end else if (fire && cnt_ge1) begin
			rd_ptr_d = rd_nxt;
		end
	end

	assign count_d = count_q + (push_ok ? CW'(1) : '0) - pops;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			enable_q <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				tsatf_pkg::REG_PERIOD: period_q <= wr_data;
				tsatf_pkg::REG_ENABLE: enable_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q  <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (is_tick) begin
				timer_q <= fire ? '0 : timer_inc;
			end
			if (push_ok) begin
				wr_ptr_q <= wr_nxt;
			end
			rd_ptr_q <= rd_ptr_d;
			count_q  <= count_d;
		end
	end

	// word store: one write, two registered reads
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[wr_ptr_q] <= word_s1;
		end
		if (adv_s1) begin
			rd0_s2 <= mem[rd_ptr_q];
			rd1_s2 <= mem[rd_nxt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1 <= mode;
			word_s1 <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			sample_s2     <= fire;
			left_take_s2  <= fire && cnt_ge1;
			right_take_s2 <= fire && cnt_ge2;
			under_s2      <= fire && !cnt_ge2;
			// a pop empties the store when one or two words were left
			irq_s2        <= fire && cnt_ge1 && (count_q <= CW'(2));
			empty_s2      <= (count_d == '0);
			full_s2       <= (count_d == FULL_CNT);
			ovf_s2        <= is_push && full_now;
		end
	end

	assign out_valid    = valid_s2;
	assign sample_valid = sample_s2;
	assign left_sample  = left_take_s2 ? $signed(rd0_s2) : '0;
	assign right_sample = right_take_s2 ? $signed(rd1_s2) : '0;
	assign underrun     = under_s2;
	assign irq          = irq_s2;
	assign fifo_empty   = empty_s2;
	assign fifo_full    = full_s2;
	assign overflow     = ovf_s2;
endmodule

FILE: rtl/tsatf_checker.sv
// Port-level checker for the audio transmit FIFO, bound to the top level
`timescale 1ns / 1ps
`include "timed_stereo_audio_transmit_fifo_assert.svh"
module tsatf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                sample_valid,
	input logic signed [tsatf_pkg::WORD_W-1:0] left_sample,
	input logic signed [tsatf_pkg::WORD_W-1:0] right_sample,
	input logic                                underrun,
	input logic                                irq,
	input logic                                fifo_empty,
	input logic                                fifo_full,
	input logic                                overflow
);
	// a stalled result beat stays offered
	`TSATF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped under stall")

	// a beat is a push or a tick, never both kinds of flag
	`TSATF_ASSERT_SAME(a_ovf_vs_sample, out_valid && sample_valid, !overflow, "overflow on a transmitting tick")

	`TSATF_ASSERT_SAME(a_empty_full, out_valid && fifo_empty, !fifo_full, "store empty and full at once")

	`TSATF_ASSERT_SAME(a_irq_empty, out_valid && irq, fifo_empty && sample_valid, "irq without an emptying pop")

	`TSATF_ASSERT_SAME(a_idle_zero, out_valid && !sample_valid, left_sample == '0 && right_sample == '0 && !underrun && !irq, "sample fields set without transmission")
endmodule

bind timed_stereo_audio_transmit_fifo tsatf_checker u_tsatf_checker (.*);

FILE: tb/tb_top.sv
// Self-checking testbench for the timed stereo audio transmit FIFO
`timescale 1ns / 1ps
module tb_top;
	localparam int DEPTH      = 16;
	localparam int STALL_HOLD = 300;
	localparam int DOG_LIMIT  = 3000;

	typedef struct packed {
		logic                                sample_valid;
		logic signed [tsatf_pkg::WORD_W-1:0] left_sample;
		logic signed [tsatf_pkg::WORD_W-1:0] right_sample;
		logic                                underrun;
		logic                                irq;
		logic                                fifo_empty;
		logic                                fifo_full;
		logic                                overflow;
	} tx_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             wr_en = 1'b0;
	logic [tsatf_pkg::CFG_IDX_W-1:0]  wr_index = '0;
	logic [tsatf_pkg::CFG_DATA_W-1:0] wr_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic                             mode = tsatf_pkg::MODE_TICK;
	logic [tsatf_pkg::WORD_W-1:0]     push_word = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic                             sample_valid;
	logic signed [tsatf_pkg::WORD_W-1:0] left_sample;
	logic signed [tsatf_pkg::WORD_W-1:0] right_sample;
	logic                             underrun;
	logic                             irq;
	logic                             fifo_empty;
	logic                             fifo_full;
	logic                             overflow;

	// predictor state
	logic [15:0]                  cfg_period = '0;
	logic                         cfg_enable = 1'b0;
	logic [15:0]                  pace_timer = '0;
	logic [tsatf_pkg::WORD_W-1:0] word_mem [DEPTH];
	logic [3:0]                   rd_ptr = '0;
	logic [3:0]                   wr_ptr = '0;
	int                           word_cnt = 0;

	tx_result_t pending_results[$];
	int         err_count = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_cycles = 0;

	timed_stereo_audio_transmit_fifo #(.FIFO_DEPTH(DEPTH)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .push_word(push_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.sample_valid(sample_valid), .left_sample(left_sample),
		.right_sample(right_sample), .underrun(underrun), .irq(irq),
		.fifo_empty(fifo_empty), .fifo_full(fifo_full), .overflow(overflow)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [tsatf_pkg::WORD_W-1:0] pop_word(inout logic under,
			inout logic irq_hit);
		logic [tsatf_pkg::WORD_W-1:0] w;
		if (word_cnt == 0) begin
			under = 1'b1;
			return '0;
		end
		w = word_mem[rd_ptr];
		rd_ptr = rd_ptr + 4'd1;
		word_cnt--;
		if (word_cnt == 0)
			irq_hit = 1'b1;
		return w;
	endfunction

	function automatic tx_result_t predict_fifo_step(logic md,
			logic [tsatf_pkg::WORD_W-1:0] w);
		tx_result_t r;
		r = '0;
		if (md == tsatf_pkg::MODE_PUSH) begin
			if (word_cnt >= DEPTH) begin
				r.overflow = 1'b1;
			end else begin
				word_mem[wr_ptr] = w;
				wr_ptr = wr_ptr + 4'd1;
				word_cnt++;
			end
		end else if (cfg_enable) begin
			pace_timer = pace_timer + 16'd1;
			if (pace_timer >= cfg_period) begin
				pace_timer = '0;
				r.sample_valid = 1'b1;
				r.left_sample = pop_word(r.underrun, r.irq);
				r.right_sample = pop_word(r.underrun, r.irq);
			end
		end
		r.fifo_empty = (word_cnt == 0);
		r.fifo_full = (word_cnt >= DEPTH);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint exp_v, longint got_v);
		$display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
		err_count++;
	endtask

	// one beat: optional sender gap, then hold until taken
	task automatic send_beat(logic md, logic [tsatf_pkg::WORD_W-1:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		push_word <= w;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		pending_results.push_back(predict_fifo_step(md, w));
	endtask

	// let every expected result arrive, with the sender idle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write enable drops for a cycle between writes
	task automatic write_reg(logic [tsatf_pkg::CFG_IDX_W-1:0] idx,
			logic [tsatf_pkg::CFG_DATA_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == tsatf_pkg::REG_PERIOD)
			cfg_period = val;
		else if (idx == tsatf_pkg::REG_ENABLE)
			cfg_enable = val[0];
		@(posedge clk);
	endtask

	function automatic logic [tsatf_pkg::WORD_W-1:0] rand_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return tsatf_pkg::WORD_W'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(tsatf_pkg::REG_PERIOD, '0);
		write_reg(tsatf_pkg::REG_ENABLE, 16'd0);
		send_beat(tsatf_pkg::MODE_TICK, '0);           // disabled port: no sample
		wait_drained();
		write_reg(tsatf_pkg::REG_ENABLE, 16'd1);
		send_beat(tsatf_pkg::MODE_TICK, 16'hFFFF);     // both slots underrun
		send_beat(tsatf_pkg::MODE_PUSH, 16'h8000);
		send_beat(tsatf_pkg::MODE_TICK, '0);   // left pops and empties, right underruns
		for (int i = 0; i < DEPTH; i++) begin
			if (i == 0)
				send_beat(tsatf_pkg::MODE_PUSH, '0);
			else if (i == DEPTH - 1)
				send_beat(tsatf_pkg::MODE_PUSH, '1);
			else
				send_beat(tsatf_pkg::MODE_PUSH,
					(i % 2) ? ~(16'h1 << i) : (16'h1 << i));
		end
		send_beat(tsatf_pkg::MODE_PUSH, 16'h1234);     // full: dropped
		wait_drained();
		write_reg(tsatf_pkg::REG_PERIOD, 16'd3);
		repeat (3) send_beat(tsatf_pkg::MODE_TICK, '0);
		wait_drained();
		write_reg(tsatf_pkg::REG_PERIOD, 16'd9);
		repeat (2) send_beat(tsatf_pkg::MODE_TICK, '0);
		wait_drained();
		// period dropped under the running timer
		write_reg(tsatf_pkg::REG_PERIOD, 16'd1);
		send_beat(tsatf_pkg::MODE_TICK, '0);
		wait_drained();
		write_reg(tsatf_pkg::REG_PERIOD, 16'd4);
		send_beat(tsatf_pkg::MODE_TICK, '0);
		wait_drained();
		// timer must survive a disable
		write_reg(tsatf_pkg::REG_ENABLE, 16'd0);
		send_beat(tsatf_pkg::MODE_TICK, '0);
		wait_drained();
		write_reg(tsatf_pkg::REG_ENABLE, 16'd1);
		repeat (3) send_beat(tsatf_pkg::MODE_TICK, '0);
		wait_drained();
	endtask

	task automatic test_random_phase(int n, int per, bit en, int idle_pct, int stall_pct,
			int push_pct);
		write_reg(tsatf_pkg::REG_PERIOD, tsatf_pkg::CFG_DATA_W'(per));
		write_reg(tsatf_pkg::REG_ENABLE, tsatf_pkg::CFG_DATA_W'(en));
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < push_pct)
				send_beat(tsatf_pkg::MODE_PUSH, rand_word());
			else
				send_beat(tsatf_pkg::MODE_TICK, tsatf_pkg::WORD_W'($urandom));
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		write_reg(tsatf_pkg::REG_PERIOD, 16'd0);
		write_reg(tsatf_pkg::REG_ENABLE, 16'd1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = STALL_HOLD;
		for (int i = 0; i < 48; i++)
			send_beat($urandom_range(2) != 0 ? tsatf_pkg::MODE_PUSH : tsatf_pkg::MODE_TICK,
				rand_word());
		// sender pauses until everything is out
		wait_drained();
		for (int i = 0; i < 24; i++)
			send_beat($urandom_range(1) ? tsatf_pkg::MODE_PUSH : tsatf_pkg::MODE_TICK,
				rand_word());
		wait_drained();
	endtask

	// receiver side: random stalls, or a long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// result beats are checked at the falling edge ahead of the accepting edge
	initial begin
		tx_result_t exp_r;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t result beat with nothing expected", $realtime);
					err_count++;
				end else begin
					exp_r = pending_results.pop_front();
					if (sample_valid !== exp_r.sample_valid)
						report_mismatch("sample_valid", exp_r.sample_valid, sample_valid);
					if (left_sample !== exp_r.left_sample)
						report_mismatch("left_sample", exp_r.left_sample, left_sample);
					if (right_sample !== exp_r.right_sample)
						report_mismatch("right_sample", exp_r.right_sample, right_sample);
					if (underrun !== exp_r.underrun)
						report_mismatch("underrun", exp_r.underrun, underrun);
					if (irq !== exp_r.irq)
						report_mismatch("irq", exp_r.irq, irq);
					if (fifo_empty !== exp_r.fifo_empty)
						report_mismatch("fifo_empty", exp_r.fifo_empty, fifo_empty);
					if (fifo_full !== exp_r.fifo_full)
						report_mismatch("fifo_full", exp_r.fifo_full, fifo_full);
					if (overflow !== exp_r.overflow)
						report_mismatch("overflow", exp_r.overflow, overflow);
				end
			end
		end
	end

	// watchdog: cycles with no beat taken on either side
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(negedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= DOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(250, 0, 1'b1, 0, 0, 67);
		test_random_phase(250, 1, 1'b1, 72, 0, 67);
		test_random_phase(250, 2, 1'b1, 0, 72, 50);
		test_random_phase(250, 7, 1'b1, 9, 9, 30);
		test_backpressure();
		test_random_phase(40, 65535, 1'b1, 9, 9, 50);
		test_random_phase(40, 3, 1'b0, 0, 0, 50);
		test_random_phase(100, 0, 1'b1, 9, 9, 55);
		wait_drained();
		repeat (8) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+rtl
rtl/tsatf_pkg.sv
rtl/timed_stereo_audio_transmit_fifo.sv
rtl/tsatf_checker.sv
tb/tb_top.sv
